/* sv/fqtr_pkg.sv */
// ----------------------------------------------------------------------------
// fqtr_pkg
// Shared types and constants of the quarter-turn frame rotator.
// ----------------------------------------------------------------------------
`default_nettype none

package fqtr_pkg;

  // Field widths
  localparam int PIXEL_W     = 32;
  localparam int ANGLE_W     = 16;
  localparam int SIZE_W      = 7;
  localparam int SIZE_LIMIT  = 127;
  localparam int COUNT_W     = 2 * SIZE_W;
  localparam int CFG_INDEX_W = 2;

  // Register indexes of the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_ANGLE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT = 2'd2;

  // Command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Angle reduction: bias makes any 16-bit angle positive (a multiple of 360),
  // then one conditional subtract of 360 << k per step, k = 7 down to 0.
  localparam int REM_W        = ANGLE_W + 1;
  localparam int REDUCE_STEPS = 8;
  localparam int REDUCE_CNT_W = 4;
  localparam int SHIFT_W      = 3;
  localparam logic [REM_W-1:0] ANGLE_MOD   = 17'd360;
  localparam logic [REM_W-1:0] ANGLE_BIAS  = 17'd33120;
  localparam logic [REM_W-1:0] ANGLE_QTR   = 17'd90;
  localparam logic [REM_W-1:0] ANGLE_HALF  = 17'd180;

  // Reset sizes
  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  typedef enum logic [1:0] {
    Q_0,
    Q_90,
    Q_180,
    Q_270
  } quarter_t;

  // One store operation, as handed from front to back
  typedef struct packed {
    logic                 is_read;
    logic                 last;
    logic [PIXEL_W-1:0]   pixel;
    logic [COUNT_W-1:0]   index;
  } op_t;

endpackage

`default_nettype wire

/* sv/fqtr_front.sv */
// ----------------------------------------------------------------------------
// fqtr_front
// Takes commands and configuration, reduces the angle, steps the load and
// read positions and turns each command into a store operation.
// ----------------------------------------------------------------------------
`default_nettype none

module fqtr_front #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fqtr_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [fqtr_pkg::ANGLE_W-1:0]      cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              command,
  input  logic [fqtr_pkg::PIXEL_W-1:0]      pixel_in,
  input  logic                              queue_full,
  output logic                              push,
  output fqtr_pkg::op_t                     op
);

  import fqtr_pkg::*;

  localparam int W_CAP = (MAX_WIDTH > SIZE_LIMIT) ? SIZE_LIMIT : MAX_WIDTH;
  localparam int H_CAP = (MAX_HEIGHT > SIZE_LIMIT) ? SIZE_LIMIT : MAX_HEIGHT;
  localparam logic [SIZE_W-1:0] W_MAX = SIZE_W'(W_CAP);
  localparam logic [SIZE_W-1:0] H_MAX = SIZE_W'(H_CAP);
  localparam logic [SIZE_W-1:0] ONE   = SIZE_W'(1);
  localparam int W_RST = (int'(SIZE_RESET) > W_CAP) ? W_CAP : int'(SIZE_RESET);
  localparam int H_RST = (int'(SIZE_RESET) > H_CAP) ? H_CAP : int'(SIZE_RESET);
  localparam logic [COUNT_W-1:0] TOTAL_RESET = COUNT_W'(W_RST * H_RST);

  logic [ANGLE_W-1:0]       angle_reg;
  logic [SIZE_W-1:0]        width_reg;
  logic [SIZE_W-1:0]        height_reg;
  logic [REM_W-1:0]         rem;
  logic [REDUCE_CNT_W-1:0]  reduce_cnt;
  logic [COUNT_W-1:0]       total;
  logic [COUNT_W-1:0]       load_position;
  logic [COUNT_W-1:0]       load_position_next;
  logic [SIZE_W-1:0]        out_column;
  logic [SIZE_W-1:0]        out_row;
  logic [SIZE_W-1:0]        out_column_next;
  logic [SIZE_W-1:0]        out_row_next;

  logic                     cfg_write;
  logic                     busy;
  logic                     accept;
  logic [SIZE_W-1:0]        w;
  logic [SIZE_W-1:0]        h;
  logic [SIZE_W-1:0]        dw;
  logic [SIZE_W-1:0]        dh;
  logic [SHIFT_W-1:0]       shift;
  logic [REM_W-1:0]         sub;
  quarter_t                 quarter;
  logic [COUNT_W-1:0]       lp;
  logic [COUNT_W-1:0]       lp_inc;
  logic [SIZE_W-1:0]        c;
  logic [SIZE_W-1:0]        r;
  logic [SIZE_W-1:0]        sx;
  logic [SIZE_W-1:0]        sy;
  logic                     last;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign busy      = (reduce_cnt != '0);
  assign in_stall  = busy || queue_full;
  assign accept    = in_valid && !in_stall;
  assign push      = accept;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_reg  <= '0;
      width_reg  <= SIZE_RESET;
      height_reg <= SIZE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ANGLE:  angle_reg  <= cfg_data;
        REG_WIDTH:  width_reg  <= cfg_data[SIZE_W-1:0];
        REG_HEIGHT: height_reg <= cfg_data[SIZE_W-1:0];
        default:    ;
      endcase
    end
  end

  // Clamped sizes and frame pixel count
  always_comb begin
    w = (width_reg == '0) ? ONE : ((width_reg > W_MAX) ? W_MAX : width_reg);
    h = (height_reg == '0) ? ONE : ((height_reg > H_MAX) ? H_MAX : height_reg);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= TOTAL_RESET;
    end else begin
      total <= COUNT_W'(w) * COUNT_W'(h);
    end
  end

  // Angle reduction: a load step of the remainder, then one subtract step per cycle
  assign shift = SHIFT_W'(reduce_cnt - REDUCE_CNT_W'(1));
  assign sub   = ANGLE_MOD << shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      reduce_cnt <= '0;
      rem        <= '0;
    end else if (cfg_write) begin
      reduce_cnt <= REDUCE_CNT_W'(REDUCE_STEPS + 1);
    end else if (reduce_cnt == REDUCE_CNT_W'(REDUCE_STEPS + 1)) begin
      rem        <= {angle_reg[ANGLE_W-1], angle_reg} + ANGLE_BIAS;
      reduce_cnt <= reduce_cnt - REDUCE_CNT_W'(1);
    end else if (busy) begin
      if (rem >= sub) begin
        rem <= rem - sub;
      end
      reduce_cnt <= reduce_cnt - REDUCE_CNT_W'(1);
    end
  end

  always_comb begin
    if (rem == '0) begin
      quarter = Q_0;
    end else if (rem == ANGLE_QTR) begin
      quarter = Q_90;
    end else if (rem == ANGLE_HALF) begin
      quarter = Q_180;
    end else begin
      quarter = Q_270;
    end
  end

  // Load position, wrapping at the frame size
  always_comb begin
    lp     = (load_position >= total) ? '0 : load_position;
    lp_inc = lp + COUNT_W'(1);
    load_position_next = (lp_inc >= total) ? '0 : lp_inc;
  end

  // Destination coordinate and the source pixel it maps to
  always_comb begin
    if (quarter == Q_90 || quarter == Q_270) begin
      dw = h;
      dh = w;
    end else begin
      dw = w;
      dh = h;
    end
    if (out_column >= dw || out_row >= dh) begin
      c = '0;
      r = '0;
    end else begin
      c = out_column;
      r = out_row;
    end
    case (quarter)
      Q_0: begin
        sx = c;
        sy = r;
      end
      Q_180: begin
        sx = w - ONE - c;
        sy = h - ONE - r;
      end
      Q_90: begin
        sx = r;
        sy = h - ONE - c;
      end
      default: begin
        sx = w - ONE - r;
        sy = c;
      end
    endcase
    last = (c == dw - ONE) && (r == dh - ONE);
    if (c + ONE < dw) begin
      out_column_next = c + ONE;
      out_row_next    = r;
    end else begin
      out_column_next = '0;
      out_row_next    = (r + ONE < dh) ? r + ONE : '0;
    end
  end

  // Operation word for the queue
  always_comb begin
    op.is_read = (command == CMD_READ);
    op.last    = last;
    op.pixel   = pixel_in;
    if (command == CMD_READ) begin
      op.index = COUNT_W'(sy) * COUNT_W'(w) + COUNT_W'(sx);
    end else begin
      op.index = lp;
    end
  end

  // Position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      load_position <= '0;
      out_column    <= '0;
      out_row       <= '0;
    end else if (accept) begin
      if (command == CMD_READ) begin
        out_column <= out_column_next;
        out_row    <= out_row_next;
      end else begin
        load_position <= load_position_next;
      end
    end
  end

  // A config write holds off commands until the angle is reduced
  a_cfg_holds_input: assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> in_stall)
    else $error("command accepted right after a config write");

  // Eight steps always bring the remainder below one full turn
  a_reduce_done: assert property (@(posedge clk) disable iff (rst)
    (reduce_cnt == REDUCE_CNT_W'(1)) && !cfg_write |=> rem < ANGLE_MOD)
    else $error("angle remainder not reduced");

  // Nothing is pushed into a full queue
  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !queue_full)
    else $error("command pushed into a full queue");

endmodule

`default_nettype wire

/* sv/fqtr_queue.sv */
// ----------------------------------------------------------------------------
// fqtr_queue
// Short queue of store operations between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module fqtr_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  fqtr_pkg::op_t  op_in,
  output logic           full,
  input  logic           pop,
  output fqtr_pkg::op_t  head,
  output logic           empty
);

  import fqtr_pkg::*;

  op_t                entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;

  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= op_in;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: ;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("pop from an empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

`default_nettype wire

/* sv/fqtr_back.sv */
// ----------------------------------------------------------------------------
// fqtr_back
// Frame store and output register: writes loads, reads rotated pixels.
// ----------------------------------------------------------------------------
`default_nettype none

module fqtr_back #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  fqtr_pkg::op_t                 head,
  input  logic                          queue_empty,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [fqtr_pkg::PIXEL_W-1:0]  pixel_out,
  output logic                          last_pixel
);

  import fqtr_pkg::*;

  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW          = $clog2(STORE_DEPTH);

  logic [PIXEL_W-1:0]  store [STORE_DEPTH];
  logic [AW-1:0]       addr;
  logic                rd_issue;
  logic                wr_issue;

  assign addr     = AW'(head.index);
  assign wr_issue = !queue_empty && !head.is_read;
  assign rd_issue = !queue_empty && head.is_read && (!out_valid || !out_stall);
  assign pop      = wr_issue || rd_issue;

  // Frame store, read data lands in the output register
  always_ff @(posedge clk) begin
    if (wr_issue) begin
      store[addr] <= head.pixel;
    end
    if (rd_issue) begin
      pixel_out  <= store[addr];
      last_pixel <= head.last;
    end
  end

  // Output word valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rd_issue) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  a_read_shows: assert property (@(posedge clk) disable iff (rst)
    rd_issue |=> out_valid)
    else $error("issued read did not produce an output word");

  // A stalled output word holds still
  a_stalled_word_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=>
      out_valid && $stable(pixel_out) && $stable(last_pixel))
    else $error("stalled output word changed");

  a_pop_has_head: assert property (@(posedge clk) disable iff (rst)
    pop |-> !queue_empty)
    else $error("pop without a queued operation");

endmodule

`default_nettype wire

/* sv/frame_quarter_turn_rotator.sv */
// ----------------------------------------------------------------------------
// frame_quarter_turn_rotator
// Rotates a frame of 32-bit RGBA pixels by 0, 90, 180 or 270 degrees. A load
// command (command = 0) writes pixel_in to the next source position in raster
// order; a read command (command = 1) returns the next pixel of the rotated
// frame in raster order, with last_pixel set on the frame's final pixel. The
// angle register is reduced modulo 360; anything but 0, 90 or 180 acts as a
// counter-clockwise quarter turn (270). Sizes are clamped to 1..MAX, at most
// 127. Every store entry must be loaded before it is read. Throughput is one
// command per clock while in_stall is low; a read word goes through a
// two-entry operation queue and then the store's registered read port.
// After any configuration write, commands are held off while the angle is
// loaded and then reduced by one compare-and-subtract step per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_quarter_turn_rotator #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fqtr_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [fqtr_pkg::ANGLE_W-1:0]      cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              command,
  input  logic [fqtr_pkg::PIXEL_W-1:0]      pixel_in,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [fqtr_pkg::PIXEL_W-1:0]      pixel_out,
  output logic                              last_pixel
);

  import fqtr_pkg::*;

  logic  push;
  logic  pop;
  logic  queue_full;
  logic  queue_empty;
  op_t   op;
  op_t   head;

  fqtr_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .pixel_in   (pixel_in),
    .queue_full (queue_full),
    .push       (push),
    .op         (op)
  );

  fqtr_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .op_in (op),
    .full  (queue_full),
    .pop   (pop),
    .head  (head),
    .empty (queue_empty)
  );

  fqtr_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .queue_empty (queue_empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_out   (pixel_out),
    .last_pixel  (last_pixel)
  );

endmodule

`default_nettype wire
